@@ sv/prt_pkg.sv @@
// Package for the pending reservation table unit.
// Holds the operation, status and entry codes and the shared item types.
// Depends on nothing.
package prt_pkg;

    localparam logic [2:0] OP_ENQ     = 3'd0;
    localparam logic [2:0] OP_RESERVE = 3'd1;
    localparam logic [2:0] OP_COMMIT  = 3'd2;
    localparam logic [2:0] OP_RELEASE = 3'd3;
    localparam logic [2:0] OP_PEEK    = 3'd4;

    localparam logic [1:0] RS_DONE    = 2'd0;
    localparam logic [1:0] RS_REFUSED = 2'd1;
    localparam logic [1:0] RS_MISS    = 2'd2;

    localparam logic [1:0] ES_FREE     = 2'd0;
    localparam logic [1:0] ES_READY    = 2'd1;
    localparam logic [1:0] ES_RESERVED = 2'd2;

    localparam logic [31:0] MIN_BYTES_RESET = 32'd16;
    localparam logic [47:0] TICKET_MAX      = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]  state;
        logic [47:0] ticket;
        logic [31:0] bytes;
        logic [31:0] addr;
    } entry_t;

    typedef struct packed {
        logic [2:0]  op;
        logic        refused;
        logic [31:0] byte_count;
        logic [31:0] buffer_addr;
        logic [47:0] ticket_in;
    } cmd_t;

endpackage

@@ sv/prt_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module prt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/prt_queue.sv @@
// Two-entry command queue between the front and the back of the table unit.
// Depends on prt_pkg.
module prt_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  prt_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output prt_pkg::cmd_t pop_data,
    output logic          empty
);
    import prt_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

@@ sv/prt_front.sv @@
// Front end of the table unit: holds the minimum byte count register and
// classifies each item as refused or to be carried out. Depends on prt_pkg.
module prt_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [31:0]   cfg_data,
    input  logic [2:0]    op,
    input  logic [31:0]   byte_count,
    input  logic [31:0]   buffer_addr,
    input  logic [47:0]   ticket_in,
    output prt_pkg::cmd_t cmd
);
    import prt_pkg::*;

    logic [31:0] min_bytes_reg;
    logic        short_count;
    logic        needs_count;
    logic        needs_ticket;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_bytes_reg <= MIN_BYTES_RESET;
        end
        else if (cfg_valid)
        begin
            min_bytes_reg <= cfg_data;
        end
    end

    always_comb
    begin
        short_count  = (byte_count < min_bytes_reg);
        needs_count  = (op == OP_ENQ) || (op == OP_RESERVE) || (op == OP_PEEK);
        needs_ticket = (op == OP_COMMIT) || (op == OP_RELEASE);
        cmd.op          = op;
        cmd.byte_count  = byte_count;
        cmd.buffer_addr = buffer_addr;
        cmd.ticket_in   = ticket_in;
        cmd.refused     = (op > OP_PEEK)
                       || (needs_count && short_count)
                       || ((op == OP_ENQ) && (buffer_addr == 32'd0))
                       || (needs_ticket && (ticket_in == 48'd0));
    end

endmodule

@@ sv/prt_back.sv @@
// Back end of the table unit: scans the entry RAM one entry a cycle, applies
// the operation and holds the result until it is taken. Depends on prt_pkg, prt_ram.
module prt_back #(
    parameter int ENTRIES = 128
) (
    input  logic          clk,
    input  logic          rst_n,
    input  prt_pkg::cmd_t q_data,
    input  logic          q_empty,
    output logic          q_pop,
    output logic          busy,
    input  logic          pop,
    output logic          empty,
    output logic [1:0]    status,
    output logic [47:0]   ticket_out,
    output logic [31:0]   addr_out,
    output logic          evicted,
    output logic [7:0]    occupancy
);
    import prt_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_SCAN, B_EXEC} bstate_t;

    bstate_t     state_reg;
    cmd_t        cmd_reg;
    logic [CW-1:0] cnt_reg;
    logic        dvalid_reg;
    logic [IW-1:0] didx_reg;
    logic        free_found_reg;
    logic [IW-1:0] free_idx_reg;
    logic        hit_found_reg;
    logic [IW-1:0] hit_idx_reg;
    entry_t      hit_word_reg;
    logic [CW-1:0] occ_reg;
    logic [47:0] tc_reg;
    logic        res_valid_reg;
    logic [1:0]  status_reg;
    logic [47:0] tout_reg;
    logic [31:0] aout_reg;
    logic        ev_reg;
    logic [7:0]  occ_out_reg;

    entry_t      rd_word;
    logic        issue;
    logic        ram_we;
    logic [IW-1:0] ram_waddr;
    entry_t      ram_wdata;
    logic        cand;
    logic        take;
    logic        fire;
    logic [1:0]  ex_status;
    logic [47:0] ex_tout;
    logic [31:0] ex_aout;
    logic        ex_ev;
    logic        ex_we;
    logic [IW-1:0] ex_idx;
    entry_t      ex_word;
    logic [CW-1:0] occ_next;
    logic [47:0] tc_next;
    logic [31:0] occ_wide;

    assign issue  = (state_reg == B_SCAN) && (cnt_reg != CW'(ENTRIES));
    assign fire   = (state_reg == B_EXEC) && (!res_valid_reg || pop);
    assign q_pop  = (state_reg == B_IDLE) && !q_empty;
    assign busy   = (state_reg == B_CLEAR);
    assign empty  = !res_valid_reg;
    assign status     = status_reg;
    assign ticket_out = tout_reg;
    assign addr_out   = aout_reg;
    assign evicted    = ev_reg;
    assign occupancy  = occ_out_reg;

    prt_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cnt_reg[IW-1:0]),
        .rdata (rd_word)
    );

    always_comb
    begin
        case (cmd_reg.op)
            OP_ENQ:
            begin
                cand = (rd_word.state == ES_READY);
            end
            OP_RESERVE:
            begin
                cand = (rd_word.state == ES_READY) && (rd_word.bytes == cmd_reg.byte_count);
            end
            OP_PEEK:
            begin
                cand = ((rd_word.state == ES_READY) || (rd_word.state == ES_RESERVED))
                    && (rd_word.bytes == cmd_reg.byte_count);
            end
            OP_COMMIT, OP_RELEASE:
            begin
                cand = (rd_word.state == ES_RESERVED)
                    && (rd_word.ticket == cmd_reg.ticket_in);
            end
            default:
            begin
                cand = 1'b0;
            end
        endcase
        take = cand && (!hit_found_reg || (rd_word.ticket < hit_word_reg.ticket));
    end

    always_comb
    begin
        ex_status = RS_DONE;
        ex_tout   = 48'd0;
        ex_aout   = 32'd0;
        ex_ev     = 1'b0;
        ex_we     = 1'b0;
        ex_idx    = hit_idx_reg;
        ex_word   = hit_word_reg;
        occ_next  = occ_reg;
        tc_next   = tc_reg;
        if (cmd_reg.refused)
        begin
            ex_status = RS_REFUSED;
        end
        else
        begin
            case (cmd_reg.op)
                OP_ENQ:
                begin
                    if (tc_reg == TICKET_MAX)
                    begin
                        ex_status = RS_REFUSED;
                    end
                    else if (free_found_reg || hit_found_reg)
                    begin
                        tc_next        = tc_reg + 48'd1;
                        ex_we          = 1'b1;
                        ex_tout        = tc_next;
                        ex_word.state  = ES_READY;
                        ex_word.ticket = tc_next;
                        ex_word.bytes  = cmd_reg.byte_count;
                        ex_word.addr   = cmd_reg.buffer_addr;
                        if (free_found_reg)
                        begin
                            ex_idx   = free_idx_reg;
                            occ_next = occ_reg + CW'(1);
                        end
                        else
                        begin
                            ex_ev = 1'b1;
                        end
                    end
                    else
                    begin
                        ex_status = RS_MISS;
                    end
                end
                OP_RESERVE:
                begin
                    if (hit_found_reg)
                    begin
                        ex_we         = 1'b1;
                        ex_word.state = ES_RESERVED;
                        ex_tout       = hit_word_reg.ticket;
                        ex_aout       = hit_word_reg.addr;
                    end
                    else
                    begin
                        ex_status = RS_MISS;
                    end
                end
                OP_COMMIT:
                begin
                    if (hit_found_reg)
                    begin
                        ex_we    = 1'b1;
                        ex_word  = '0;
                        occ_next = occ_reg - CW'(1);
                    end
                    else
                    begin
                        ex_status = RS_MISS;
                    end
                end
                OP_RELEASE:
                begin
                    if (hit_found_reg)
                    begin
                        ex_we         = 1'b1;
                        ex_word.state = ES_READY;
                    end
                    else
                    begin
                        ex_status = RS_MISS;
                    end
                end
                OP_PEEK:
                begin
                    if (hit_found_reg)
                    begin
                        ex_aout = hit_word_reg.addr;
                    end
                    else
                    begin
                        ex_status = RS_MISS;
                    end
                end
                default:
                begin
                    ex_status = RS_REFUSED;
                end
            endcase
        end
        occ_wide = 32'(occ_next);
    end

    always_comb
    begin
        if (state_reg == B_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = cnt_reg[IW-1:0];
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = fire && ex_we;
            ram_waddr = ex_idx;
            ram_wdata = ex_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_CLEAR;
            cnt_reg        <= '0;
            dvalid_reg     <= 1'b0;
            free_found_reg <= 1'b0;
            hit_found_reg  <= 1'b0;
            occ_reg        <= '0;
            tc_reg         <= 48'd0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            dvalid_reg <= issue;
            didx_reg   <= cnt_reg[IW-1:0];
            if (fire)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (pop && res_valid_reg)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_CLEAR:
                begin
                    if (cnt_reg == CW'(ENTRIES - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= B_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                B_IDLE:
                begin
                    if (!q_empty)
                    begin
                        cmd_reg        <= q_data;
                        free_found_reg <= 1'b0;
                        hit_found_reg  <= 1'b0;
                        cnt_reg        <= '0;
                        state_reg      <= q_data.refused ? B_EXEC : B_SCAN;
                    end
                end
                B_SCAN:
                begin
                    if (issue)
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                    if (dvalid_reg)
                    begin
                        if (!free_found_reg && (rd_word.state == ES_FREE))
                        begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= didx_reg;
                        end
                        if (take)
                        begin
                            hit_found_reg <= 1'b1;
                            hit_idx_reg   <= didx_reg;
                            hit_word_reg  <= rd_word;
                        end
                        if (didx_reg == IW'(ENTRIES - 1))
                        begin
                            state_reg <= B_EXEC;
                        end
                    end
                end
                B_EXEC:
                begin
                    if (fire)
                    begin
                        status_reg    <= ex_status;
                        tout_reg      <= ex_tout;
                        aout_reg      <= ex_aout;
                        ev_reg        <= ex_ev;
                        occ_out_reg   <= (occ_wide > 32'd255) ? 8'hFF : occ_wide[7:0];
                        occ_reg       <= occ_next;
                        tc_reg        <= tc_next;
                        state_reg     <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

@@ sv/pending_reservation_table_unit.sv @@
// Pending reservation table unit: top level joining front, queue and back.
// An item's result waits on a scan of the entry RAM, one entry per cycle; a
// refused item skips the scan. Items are carried out one at a time; the next
// item leaves the queue only once the last one's result is registered.
// After reset a clearing pass frees every entry while full is high.
module pending_reservation_table_unit #(
    parameter int ENTRIES = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  op,
    input  logic [31:0] byte_count,
    input  logic [31:0] buffer_addr,
    input  logic [47:0] ticket_in,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  status,
    output logic [47:0] ticket_out,
    output logic [31:0] addr_out,
    output logic        evicted,
    output logic [7:0]  occupancy,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);
    import prt_pkg::*;

    cmd_t cmd;
    cmd_t q_data;
    logic q_full;
    logic q_empty;
    logic q_pop;
    logic busy;

    assign full = q_full || busy;

    prt_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .op          (op),
        .byte_count  (byte_count),
        .buffer_addr (buffer_addr),
        .ticket_in   (ticket_in),
        .cmd         (cmd)
    );

    prt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push && !full),
        .push_data (cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    prt_back #(
        .ENTRIES(ENTRIES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_data     (q_data),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .busy       (busy),
        .pop        (pop),
        .empty      (empty),
        .status     (status),
        .ticket_out (ticket_out),
        .addr_out   (addr_out),
        .evicted    (evicted),
        .occupancy  (occupancy)
    );

endmodule

@@ sv/prt_checker.sv @@
// Port-level checker for the pending reservation table unit, bound to the top.
// Depends on prt_pkg and pending_reservation_table_unit.
module prt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  status,
    input logic [47:0] ticket_out,
    input logic        evicted
);
    import prt_pkg::*;

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (status <= RS_MISS))
        else $error("result status code out of range");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(status) && $stable(ticket_out)))
        else $error("waiting result changed");

    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (status != RS_DONE)) |-> ((ticket_out == 48'd0) && !evicted))
        else $error("failed item carries a ticket or eviction");

    a_evict_ticket: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && evicted) |-> ((status == RS_DONE) && (ticket_out != 48'd0)))
        else $error("eviction without an assigned ticket");

endmodule

bind pending_reservation_table_unit prt_checker u_prt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .pop        (pop),
    .status     (status),
    .ticket_out (ticket_out),
    .evicted    (evicted)
);
